// ===== hdl/nmtf_pkg.sv =====
// shared constants and types of the non-manifold triangle filter
package nmtf_pkg;

	localparam int TABLE_ENTRIES_DEF = 4096;
	localparam int INDEX_BITS_DEF    = 24;
	localparam int VERTEX_W          = 24;
	localparam int TOTAL_W           = 24;
	localparam int QUEUE_DEPTH       = 2;
	localparam int S_TDATA_W         = 72;
	localparam int M_TDATA_W         = 32;

	localparam logic [1:0]         SHARE_LIMIT = 2'd2;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;

	typedef enum logic [1:0] {
		CAUSE_KEPT,
		CAUSE_DEGEN,
		CAUSE_SHARED,
		CAUSE_FULL
	} cause_t;

endpackage

// ===== hdl/nmtf_ram.sv =====
// generic single-port-write, registered-read ram
module nmtf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/nmtf_fifo.sv =====
// short queue between the classifying front and the table back end
module nmtf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    fill_q;
	logic             push;
	logic             pop;

	assign in_ready  = (fill_q != CW'(DEPTH));
	assign out_valid = (fill_q != '0);
	assign out_data  = slot_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_data;
		end
	end

endmodule

// ===== hdl/nmtf_front.sv =====
// front end: takes triangles, flags degenerate ones, orders edges and hashes them
module nmtf_front
	import nmtf_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int INDEX_BITS    = INDEX_BITS_DEF,
	localparam int ITEM_W = 2 + 6 * INDEX_BITS + 3 * $clog2(TABLE_ENTRIES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tuser,
	output logic                 tri_valid,
	input  logic                 tri_ready,
	output logic [ITEM_W-1:0]    tri_data
);

	localparam int LOG   = $clog2(TABLE_ENTRIES);
	localparam int PW    = LOG + 1;
	localparam int EXT_W = VERTEX_W + INDEX_BITS;
	localparam int HW    = INDEX_BITS + PW;

	typedef struct packed {
		logic                        new_mesh;
		logic                        degen;
		logic [2:0][INDEX_BITS-1:0]  lo;
		logic [2:0][INDEX_BITS-1:0]  hi;
		logic [2:0][LOG-1:0]         hash;
	} tri_t;

	logic                       rdy1;
	logic                       rdy2;
	logic                       rdy3;
	logic [2:0][INDEX_BITS-1:0] vtx_d;
	logic [2:0][INDEX_BITS-1:0] lo_d;
	logic [2:0][INDEX_BITS-1:0] hi_d;
	logic [2:0][PW-1:0]         sum_d;
	logic [2:0][PW-1:0]         inc_d;
	logic [2:0][PW-1:0]         prod_d;
	logic [2:0][LOG-1:0]        hash_d;
	logic                       degen_d;
	tri_t                       tri_d;

	logic                       v_s1;
	logic [2:0][INDEX_BITS-1:0] vtx_s1;
	logic                       new_s1;
	logic                       v_s2;
	logic                       new_s2;
	logic                       degen_s2;
	logic [2:0][INDEX_BITS-1:0] lo_s2;
	logic [2:0][INDEX_BITS-1:0] hi_s2;
	logic [2:0][PW-1:0]         sum_s2;
	logic [2:0][PW-1:0]         inc_s2;
	logic                       v_s3;
	logic                       new_s3;
	logic                       degen_s3;
	logic [2:0][INDEX_BITS-1:0] lo_s3;
	logic [2:0][INDEX_BITS-1:0] hi_s3;
	logic [2:0][PW-1:0]         prod_s3;

	assign rdy3          = !v_s3 || tri_ready;
	assign rdy2          = !v_s2 || rdy3;
	assign rdy1          = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	for (genvar k = 0; k < 3; k++) begin : g_vtx
		logic [EXT_W-1:0] v_x;
		assign v_x      = EXT_W'(s_axis_tdata[k*VERTEX_W +: VERTEX_W]);
		assign vtx_d[k] = v_x[INDEX_BITS-1:0];
	end

	assign degen_d = (vtx_s1[0] == vtx_s1[1]) || (vtx_s1[1] == vtx_s1[2]) ||
		(vtx_s1[2] == vtx_s1[0]);

	// pairing hash: only the low bits of s*(s+1) matter once masked to the table
	for (genvar e = 0; e < 3; e++) begin : g_edge
		logic [INDEX_BITS-1:0] p;
		logic [INDEX_BITS-1:0] q;
		logic [HW-1:0]         lo_x;
		logic [HW-1:0]         hi_x;
		logic [HW-1:0]         hi3_x;
		logic [2*PW-1:0]       prod;

		assign p         = vtx_s1[e];
		assign q         = vtx_s1[(e + 1) % 3];
		assign lo_d[e]   = (p < q) ? p : q;
		assign hi_d[e]   = (p < q) ? q : p;
		assign lo_x      = HW'(lo_d[e]);
		assign hi_x      = HW'(hi_d[e]);
		assign sum_d[e]  = lo_x[PW-1:0] + hi_x[PW-1:0];
		assign inc_d[e]  = sum_d[e] + 1'b1;
		assign prod      = (2*PW)'(sum_s2[e]) * (2*PW)'(inc_s2[e]);
		assign prod_d[e] = prod[PW-1:0];
		assign hi3_x     = HW'(hi_s3[e]);
		assign hash_d[e] = prod_s3[e][PW-1:1] + hi3_x[LOG-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && rdy1) begin
			vtx_s1 <= vtx_d;
			new_s1 <= s_axis_tuser;
		end
		if (v_s1 && rdy2) begin
			new_s2   <= new_s1;
			degen_s2 <= degen_d;
			lo_s2    <= lo_d;
			hi_s2    <= hi_d;
			sum_s2   <= sum_d;
			inc_s2   <= inc_d;
		end
		if (v_s2 && rdy3) begin
			new_s3   <= new_s2;
			degen_s3 <= degen_s2;
			lo_s3    <= lo_s2;
			hi_s3    <= hi_s2;
			prod_s3  <= prod_d;
		end
	end

	assign tri_d.new_mesh = new_s3;
	assign tri_d.degen    = degen_s3;
	assign tri_d.lo       = lo_s3;
	assign tri_d.hi       = hi_s3;
	assign tri_d.hash     = hash_d;
	assign tri_data       = tri_d;
	assign tri_valid      = v_s3;

endmodule

// ===== hdl/nmtf_back.sv =====
// back end: probes the edge table, decides keep or drop, updates counts
module nmtf_back
	import nmtf_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int INDEX_BITS    = INDEX_BITS_DEF,
	localparam int ITEM_W = 2 + 6 * INDEX_BITS + 3 * $clog2(TABLE_ENTRIES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tri_valid,
	output logic                 tri_ready,
	input  logic [ITEM_W-1:0]    tri_data,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	localparam int LOG = $clog2(TABLE_ENTRIES);

	typedef struct packed {
		logic                        new_mesh;
		logic                        degen;
		logic [2:0][INDEX_BITS-1:0]  lo;
		logic [2:0][INDEX_BITS-1:0]  hi;
		logic [2:0][LOG-1:0]         hash;
	} tri_t;

	typedef struct packed {
		logic                  valid;
		logic [INDEX_BITS-1:0] hi;
		logic [INDEX_BITS-1:0] lo;
		logic [1:0]            cnt;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_READ,
		ST_EXAM,
		ST_DECIDE
	} state_t;

	state_t              state_q;
	tri_t                item_q;
	tri_t                tri_in;
	logic [1:0]          edge_q;
	logic                commit_q;
	logic                shared_q;
	logic [1:0]          need_q;
	logic [LOG:0]        used_q;
	logic [LOG-1:0]      slot_q;
	logic [LOG-1:0]      step_q;
	logic [LOG-1:0]      clr_q;
	logic                pend_q;
	logic [TOTAL_W-1:0]  drop_q;
	logic                out_valid_q;
	logic                out_keep_q;
	cause_t              out_cause_q;

	logic                ram_we;
	logic [LOG-1:0]      ram_waddr;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t              rd_e;
	entry_t              wr_e;
	logic [INDEX_BITS-1:0] cur_lo;
	logic [INDEX_BITS-1:0] cur_hi;
	logic                hit;
	logic                free;
	logic                stop;
	logic [1:0]          need_nx;
	logic                shared_nx;
	logic                overflow;
	logic                take;
	logic                fin;
	cause_t              fin_cause;
	logic [TOTAL_W-1:0]  drop_nx;

	assign tri_in    = tri_data;
	assign tri_ready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign take      = tri_valid && tri_ready;

	assign rd_e   = ram_rdata;
	assign cur_lo = item_q.lo[edge_q];
	assign cur_hi = item_q.hi[edge_q];
	assign hit    = rd_e.valid && (rd_e.lo == cur_lo) && (rd_e.hi == cur_hi);
	assign free   = !rd_e.valid;
	// a probe ends on the key, on an empty slot, or after wrapping the whole table
	assign stop   = hit || free || (step_q == '1);

	assign need_nx   = hit ? need_q : need_q + 1'b1;
	assign shared_nx = shared_q || (hit && (rd_e.cnt >= SHARE_LIMIT));
	assign overflow  = ((LOG+2)'(used_q) + (LOG+2)'(need_q)) > (LOG+2)'(TABLE_ENTRIES);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		wr_e      = '0;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end else if ((state_q == ST_EXAM) && commit_q && (hit || free)) begin
			ram_we    = 1'b1;
			wr_e.valid = 1'b1;
			wr_e.lo    = cur_lo;
			wr_e.hi    = cur_hi;
			wr_e.cnt   = hit ? rd_e.cnt + 2'd1 : 2'd1;
		end
	end

	always_comb begin
		fin       = 1'b0;
		fin_cause = CAUSE_KEPT;
		case (state_q)
			ST_DISPATCH: begin
				fin       = item_q.degen;
				fin_cause = CAUSE_DEGEN;
			end
			ST_DECIDE: begin
				fin       = shared_q || overflow;
				fin_cause = shared_q ? CAUSE_SHARED : CAUSE_FULL;
			end
			ST_EXAM: begin
				fin       = commit_q && stop && (edge_q == 2'd2);
				fin_cause = CAUSE_KEPT;
			end
			default: begin
				fin       = 1'b0;
				fin_cause = CAUSE_KEPT;
			end
		endcase
	end

	assign drop_nx = ((fin_cause != CAUSE_KEPT) && (drop_q != TOTAL_MAX)) ?
		drop_q + 1'b1 : drop_q;

	nmtf_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_e),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= tri_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			edge_q      <= '0;
			commit_q    <= 1'b0;
			shared_q    <= 1'b0;
			need_q      <= '0;
			used_q      <= '0;
			slot_q      <= '0;
			step_q      <= '0;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			drop_q      <= '0;
			out_valid_q <= 1'b0;
			out_keep_q  <= 1'b0;
			out_cause_q <= CAUSE_KEPT;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						used_q  <= '0;
						pend_q  <= 1'b0;
						state_q <= pend_q ? ST_DISPATCH : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						if (tri_in.new_mesh) begin
							drop_q  <= '0;
							pend_q  <= 1'b1;
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_DISPATCH;
						end
					end
				end
				ST_DISPATCH: begin
					edge_q   <= '0;
					commit_q <= 1'b0;
					shared_q <= 1'b0;
					need_q   <= '0;
					slot_q   <= item_q.hash[0];
					step_q   <= '0;
					state_q  <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_EXAM;
				end
				ST_EXAM: begin
					if (!stop) begin
						slot_q  <= slot_q + 1'b1;
						step_q  <= step_q + 1'b1;
						state_q <= ST_READ;
					end else begin
						if (!commit_q) begin
							need_q   <= need_nx;
							shared_q <= shared_nx;
						end else if (free) begin
							used_q <= used_q + 1'b1;
						end
						if (edge_q == 2'd2) begin
							state_q <= commit_q ? ST_IDLE : ST_DECIDE;
						end else begin
							edge_q  <= edge_q + 1'b1;
							slot_q  <= item_q.hash[edge_q + 2'd1];
							step_q  <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_DECIDE: begin
					// second pass re-probes so edges inserted earlier are seen
					commit_q <= 1'b1;
					edge_q   <= '0;
					slot_q   <= item_q.hash[0];
					step_q   <= '0;
					state_q  <= ST_READ;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fin) begin
				out_valid_q <= 1'b1;
				out_keep_q  <= (fin_cause == CAUSE_KEPT);
				out_cause_q <= fin_cause;
				drop_q      <= drop_nx;
				state_q     <= ST_IDLE;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_TDATA_W'({drop_q, out_cause_q, out_keep_q});

endmodule

// ===== hdl/non_manifold_triangle_filter.sv =====
// path: the front end pipeline and the queue, then the table unit, which probes the table
// for each edge once to check a triangle and, if it is kept, once more to commit it.
// the table unit takes one item per back-end pass and a degenerate triangle skips the
// probes; the single table port sets this.
// reset and every new_mesh item start a clearing pass over the table memory, during
// which no item enters the table unit.
module non_manifold_triangle_filter
	import nmtf_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int INDEX_BITS    = INDEX_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // vertex_a, vertex_b, vertex_c
	input  logic                 s_axis_tuser,  // new_mesh
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata   // keep, drop_cause, dropped_total
);

	localparam int ITEM_W = 2 + 6 * INDEX_BITS + 3 * $clog2(TABLE_ENTRIES);

	logic              push_valid;
	logic              push_ready;
	logic [ITEM_W-1:0] push_data;
	logic              pop_valid;
	logic              pop_ready;
	logic [ITEM_W-1:0] pop_data;

	nmtf_front #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.INDEX_BITS    (INDEX_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.tri_valid     (push_valid),
		.tri_ready     (push_ready),
		.tri_data      (push_data)
	);

	nmtf_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_data   (push_data),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_data  (pop_data)
	);

	nmtf_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.INDEX_BITS    (INDEX_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.tri_valid     (pop_valid),
		.tri_ready     (pop_ready),
		.tri_data      (pop_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== hdl/nmtf_checker.sv =====
// port-level assertions for the filter, bound to the top level
module nmtf_checker
	import nmtf_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);

	logic [3:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {3'b000, in_acc} - {3'b000, out_acc};
		end
	end

	a_keep_matches_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == CAUSE_KEPT)))
		else $error("keep flag disagrees with drop cause");

	a_drop_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[26:3] != '0))
		else $error("dropped item with zero drop total");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (pend_q != '0))
		else $error("result without a pending item");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result withdrawn while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

endmodule

bind non_manifold_triangle_filter nmtf_checker u_nmtf_checker (.*);
